@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the image format sniffer.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the next cycle, off while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ifs_pkg.sv @@
// Package for the image format sniffer: sizes, format codes, sequencer states
// and the brand lookup table. Depends on nothing.
`default_nettype none
package ifs_pkg;

    localparam int CAPTURE_BYTES  = 1024;
    localparam int BOX_SCAN_LIMIT = 96;
    localparam int SVG_SCAN_LIMIT = 256;

    localparam int AW = $clog2(CAPTURE_BYTES);
    localparam int HW = AW + 1;
    localparam int BW = $clog2(BOX_SCAN_LIMIT + 1);
    localparam int SW = $clog2(SVG_SCAN_LIMIT + 1);

    typedef enum logic [4:0] {
        FMT_UNKNOWN = 5'd0,
        FMT_LIVP    = 5'd1,
        FMT_JXL     = 5'd2,
        FMT_AVIF    = 5'd3,
        FMT_HEIF    = 5'd4,
        FMT_PSD     = 5'd5,
        FMT_DDS     = 5'd6,
        FMT_QOI     = 5'd7,
        FMT_BLP     = 5'd8,
        FMT_PFM     = 5'd9,
        FMT_EXR     = 5'd10,
        FMT_JP2     = 5'd11,
        FMT_TIFF    = 5'd12,
        FMT_PCX     = 5'd13,
        FMT_HDR     = 5'd14,
        FMT_PNM     = 5'd15,
        FMT_SVG     = 5'd16
    } t_fmt;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_FETCH,
        ST_FETCH_D,
        ST_B_HEAD,
        ST_B_TAG,
        ST_B_SIZE,
        ST_B_END,
        ST_B_WORD,
        ST_B_CMP,
        ST_S_WS,
        ST_S_WSC,
        ST_S_TAG,
        ST_S_TAGC,
        ST_S_L,
        ST_S_FIND,
        ST_S_FINDC,
        ST_DECIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic jp2;
        logic heif;
        logic avif;
        logic jxl;
    } t_brands;

    function automatic t_brands brand_hits(input logic [31:0] w);
        t_brands h;
        h      = '0;
        h.jxl  = (w == "jxl ");
        h.avif = (w == "avif") || (w == "avis");
        h.heif = (w == "heic") || (w == "heix") || (w == "hevc") || (w == "hevx") ||
                 (w == "heim") || (w == "heis") || (w == "hevm") || (w == "hevs") ||
                 (w == "mif1") || (w == "msf1");
        h.jp2  = (w == "jp2 ") || (w == "jpx ");
        return h;
    endfunction

endpackage
`default_nettype wire

@@ src/image_format_sniffer.sv @@
// Image format sniffer: takes a file byte by byte, then classifies it.
// Depends on ifs_pkg and assert_macros.svh.
//
// Bytes are taken one per cycle while loading; the first CAPTURE_BYTES bytes go to a
// header memory. After the transfer marked tlast the input stalls while a sequencer
// walks the header memory through one registered read port: it checks the tag at each
// box offset in the first 96 bytes, reads the size of an ftyp box and compares each
// ftyp brand word, then skips leading whitespace bytes and searches for the SVG tag,
// and then decides. One format code is then offered on the output and held until
// taken.
`default_nettype none
`include "assert_macros.svh"
module image_format_sniffer import ifs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [4:0] format_code, [7:5] zero
);

    logic [7:0] r_mem [CAPTURE_BYTES];
    logic [7:0] r_lead [10];
    logic [7:0] r_q;

    t_state      r_state, n_state, r_ret, n_ret;
    logic [31:0] r_count, n_count, r_len, n_len;
    logic [HW-1:0] r_held, n_held, r_end, n_end, r_w, n_w;
    logic [BW-1:0] r_limb, n_limb, r_box, n_box;
    logic [SW-1:0] r_lims, n_lims, r_p, n_p, r_i, n_i;
    logic [AW-1:0] r_addr, n_addr;
    logic [1:0]  r_k, n_k, r_klast, n_klast;
    logic [31:0] r_word, n_word;
    logic [32:0] r_sum, n_sum;
    logic        r_bad, n_bad, r_svg, n_svg;
    t_brands     r_flags, n_flags;
    t_fmt        r_code, n_code;

    logic        acc;
    logic [31:0] cnt_inc;
    logic [31:0] alt;
    logic [BW-1:0] altc;
    logic [HW-1:0] alt_end;
    logic        bad_all;
    logic [31:0] w4;
    logic [63:0] w8;
    t_fmt        code;

    assign acc           = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {3'b000, r_code};
    assign cnt_inc       = (r_count != 32'hFFFF_FFFF) ? r_count + 32'd1 : r_count;

    always_ff @(posedge i_clk) begin
        if (acc && (r_count < 32'(CAPTURE_BYTES))) begin
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        r_q <= r_mem[r_addr];
        for (int k = 0; k < 10; k++) begin
            if (acc && (r_count == 32'(k))) begin
                r_lead[k] <= s_axis_tdata;
            end
        end
    end

    assign w4 = {r_lead[0], r_lead[1], r_lead[2], r_lead[3]};
    assign w8 = {w4, r_lead[4], r_lead[5], r_lead[6], r_lead[7]};

    always_comb begin
        priority if (r_len < 32'd2) begin
            code = FMT_UNKNOWN;
        end else if ((r_len >= 32'd8 && w8 == 64'h89504E470D0A1A0A) ||
                     (r_len >= 32'd4 && (w4 == "GIF8" || w4 == "RIFF")) ||
                     (r_len >= 32'd3 && w4[31:8] == 24'hFFD8FF)) begin
            code = FMT_UNKNOWN;
        end else if (r_len >= 32'd4 && (w4 == 32'h504B0304 || w4 == 32'h504B0506 ||
                                        w4 == 32'h504B0708)) begin
            code = FMT_LIVP;
        end else if (w4[31:16] == 16'hFF0A || r_flags.jxl) begin
            code = FMT_JXL;
        end else if (r_flags.avif) begin
            code = FMT_AVIF;
        end else if (r_flags.heif) begin
            code = FMT_HEIF;
        end else if (r_len >= 32'd4 && w4 == "8BPS") begin
            code = FMT_PSD;
        end else if (r_len >= 32'd4 && w4 == "DDS ") begin
            code = FMT_DDS;
        end else if (r_len >= 32'd4 && w4 == "qoif") begin
            code = FMT_QOI;
        end else if (r_len >= 32'd4 && (w4 == "BLP1" || w4 == "BLP2")) begin
            code = FMT_BLP;
        end else if (r_len >= 32'd3 && (w4[31:8] == "PF\n" || w4[31:8] == "Pf\n")) begin
            code = FMT_PFM;
        end else if (r_len >= 32'd4 && w4 == 32'h762F3101) begin
            code = FMT_EXR;
        end else if (r_flags.jp2 || (r_len >= 32'd8 && w8 == 64'h0000000C6A502020)) begin
            code = FMT_JP2;
        end else if (r_len >= 32'd4 && (w4 == 32'h49492A00 || w4 == 32'h4D4D002A ||
                                        w4 == 32'h49492B00 || w4 == 32'h4D4D002B)) begin
            code = FMT_TIFF;
        end else if (r_lead[0] == 8'h0A && r_len >= 32'd128) begin
            code = FMT_PCX;
        end else if ((r_len >= 32'd10 && {w8, r_lead[8], r_lead[9]} == "#?RADIANCE") ||
                     (r_len >= 32'd6 && {w4, r_lead[4], r_lead[5]} == "#?RGBE")) begin
            code = FMT_HDR;
        end else if (r_lead[0] == "P" && r_lead[1] >= "1" && r_lead[1] <= "7") begin
            code = FMT_PNM;
        end else if (r_svg) begin
            code = FMT_SVG;
        end else begin
            code = FMT_UNKNOWN;
        end
    end

    assign alt     = r_len - 32'(r_box);
    assign altc    = (alt > 32'(BOX_SCAN_LIMIT)) ? BW'(BOX_SCAN_LIMIT) : alt[BW-1:0];
    assign alt_end = HW'(r_box) + HW'(altc);
    assign bad_all = r_bad || (r_sum > {1'b0, r_len});

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_count = r_count;
        n_len   = r_len;
        n_held  = r_held;
        n_limb  = r_limb;
        n_lims  = r_lims;
        n_end   = r_end;
        n_w     = r_w;
        n_box   = r_box;
        n_p     = r_p;
        n_i     = r_i;
        n_addr  = r_addr;
        n_k     = r_k;
        n_klast = r_klast;
        n_word  = r_word;
        n_sum   = r_sum;
        n_bad   = r_bad;
        n_svg   = r_svg;
        n_flags = r_flags;
        n_code  = r_code;
        unique case (r_state)
            ST_LOAD: begin
                if (acc) begin
                    n_count = cnt_inc;
                    if (s_axis_tlast) begin
                        n_count = '0;
                        n_len   = cnt_inc;
                        n_held  = (cnt_inc > 32'(CAPTURE_BYTES)) ? HW'(CAPTURE_BYTES)
                                                                 : cnt_inc[HW-1:0];
                        n_limb  = (cnt_inc > 32'(BOX_SCAN_LIMIT)) ? BW'(BOX_SCAN_LIMIT)
                                                                  : cnt_inc[BW-1:0];
                        n_lims  = (cnt_inc > 32'(SVG_SCAN_LIMIT)) ? SW'(SVG_SCAN_LIMIT)
                                                                  : cnt_inc[SW-1:0];
                        n_box   = '0;
                        n_p     = '0;
                        n_flags = '0;
                        n_svg   = 1'b0;
                        n_state = ST_B_HEAD;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_FETCH_D;
            end
            ST_FETCH_D: begin
                n_word = {r_word[23:0], r_q};
                if (r_k == r_klast) begin
                    n_state = r_ret;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_addr  = r_addr + AW'(1);
                    n_state = ST_FETCH;
                end
            end
            ST_B_HEAD: begin
                if ((BW+1)'(r_box) + (BW+1)'(12) <= (BW+1)'(r_limb)) begin
                    n_addr  = AW'(r_box) + AW'(4);
                    n_k     = '0;
                    n_klast = 2'd3;
                    n_ret   = ST_B_TAG;
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_S_WS;
                end
            end
            ST_B_TAG: begin
                if (r_word == "ftyp") begin
                    n_addr  = AW'(r_box);
                    n_k     = '0;
                    n_klast = 2'd3;
                    n_ret   = ST_B_SIZE;
                    n_state = ST_FETCH;
                end else begin
                    n_box   = r_box + BW'(1);
                    n_state = ST_B_HEAD;
                end
            end
            ST_B_SIZE: begin
                n_sum   = {1'b0, r_word} + 33'(r_box);
                n_bad   = (r_word < 32'd16);
                n_state = ST_B_END;
            end
            ST_B_END: begin
                if (bad_all) begin
                    n_end = (alt_end > r_held) ? r_held : alt_end;
                end else begin
                    n_end = (r_sum > 33'(r_held)) ? r_held : r_sum[HW-1:0];
                end
                n_w     = HW'(r_box) + HW'(8);
                n_state = ST_B_WORD;
            end
            ST_B_WORD: begin
                if ((HW+1)'(r_w) + (HW+1)'(4) <= (HW+1)'(r_end)) begin
                    n_addr  = r_w[AW-1:0];
                    n_k     = '0;
                    n_klast = 2'd3;
                    n_ret   = ST_B_CMP;
                    n_state = ST_FETCH;
                end else begin
                    n_box   = r_box + BW'(1);
                    n_state = ST_B_HEAD;
                end
            end
            ST_B_CMP: begin
                n_flags = r_flags | brand_hits(r_word);
                n_w     = r_w + HW'(4);
                n_state = ST_B_WORD;
            end
            ST_S_WS: begin
                if (r_p < r_lims) begin
                    n_addr  = AW'(r_p);
                    n_k     = '0;
                    n_klast = 2'd0;
                    n_ret   = ST_S_WSC;
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_S_TAG;
                end
            end
            ST_S_WSC: begin
                if (r_word[7:0] == 8'h20 || r_word[7:0] == 8'h09 ||
                    r_word[7:0] == 8'h0D || r_word[7:0] == 8'h0A) begin
                    n_p     = r_p + SW'(1);
                    n_state = ST_S_WS;
                end else begin
                    n_state = ST_S_TAG;
                end
            end
            ST_S_TAG: begin
                if ((SW+1)'(r_p) + (SW+1)'(4) <= (SW+1)'(r_lims)) begin
                    n_addr  = AW'(r_p);
                    n_k     = '0;
                    n_klast = 2'd3;
                    n_ret   = ST_S_TAGC;
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_S_TAGC: begin
                if (r_word == "<svg") begin
                    n_svg   = 1'b1;
                    n_state = ST_DECIDE;
                end else if (r_word == "<?xm" &&
                             (SW+1)'(r_p) + (SW+1)'(5) <= (SW+1)'(r_lims)) begin
                    n_addr  = AW'(r_p) + AW'(4);
                    n_k     = '0;
                    n_klast = 2'd0;
                    n_ret   = ST_S_L;
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_S_L: begin
                if (r_word[7:0] == "l") begin
                    n_i     = r_p + SW'(5);
                    n_state = ST_S_FIND;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_S_FIND: begin
                if ((SW+1)'(r_i) + (SW+1)'(4) <= (SW+1)'(r_lims)) begin
                    n_addr  = AW'(r_i);
                    n_k     = '0;
                    n_klast = 2'd3;
                    n_ret   = ST_S_FINDC;
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_S_FINDC: begin
                if (r_word == "<svg") begin
                    n_svg   = 1'b1;
                    n_state = ST_DECIDE;
                end else begin
                    n_i     = r_i + SW'(1);
                    n_state = ST_S_FIND;
                end
            end
            ST_DECIDE: begin
                n_code  = code;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_len   <= n_len;
        r_held  <= n_held;
        r_limb  <= n_limb;
        r_lims  <= n_lims;
        r_end   <= n_end;
        r_w     <= n_w;
        r_box   <= n_box;
        r_p     <= n_p;
        r_i     <= n_i;
        r_addr  <= n_addr;
        r_k     <= n_k;
        r_klast <= n_klast;
        r_word  <= n_word;
        r_sum   <= n_sum;
        r_bad   <= n_bad;
        r_svg   <= n_svg;
        r_flags <= n_flags;
        r_code  <= n_code;
    end

    `ASSERT_CLK(a_sides_apart, !(s_axis_tready && m_axis_tvalid), "input and output both open")
    `ASSERT_NEXT(a_stall_after_last, acc && s_axis_tlast, !s_axis_tready, "input open after last")
    `ASSERT_CLK(a_code_range, m_axis_tvalid |-> (m_axis_tdata <= 8'd16), "format code out of range")
    `ASSERT_NEXT(a_count_cleared, m_axis_tvalid && m_axis_tready, r_count == 32'd0, "count not cleared")

endmodule
`default_nettype wire
